[rtl/svq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_pkg: shared types for the split virtqueue descriptor manager
// Opcodes, result kinds, status codes, command and result records.
// ----------------------------------------------------------------------------
package svq_pkg;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_PUSH    = 2'd1,
    OP_SUBMIT  = 2'd2,
    OP_USED    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_DESC    = 3'd1,
    KIND_RING    = 3'd2,
    KIND_PUBLISH = 3'd3,
    KIND_NOTIFY  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    STS_OK          = 3'd0,
    STS_TOO_FEW     = 3'd1,
    STS_EMPTY_CHAIN = 3'd2,
    STS_BUSY        = 3'd3,
    STS_PENDING     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } eng_state_e;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_QUEUE_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUEUE_NUMBER = 2'd1;

  typedef struct packed {
    op_e         op;
    logic [8:0]  needed;
    logic [63:0] addr;
    logic [31:0] len;
    logic        wr;
    logic [15:0] used;
    logic        suppress;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  slot;
    logic [63:0] address;
    logic [31:0] length;
    logic [1:0]  desc_flags;
    logic [7:0]  next_slot;
    logic [15:0] index_value;
    status_e     status;
    logic        last;
  } res_t;

  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  function automatic res_t status_res(status_e st);
    res_t r;
    r        = '0;
    r.kind   = KIND_STATUS;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t desc_res(logic [7:0] slot, logic [63:0] addr, logic [31:0] len,
                                    logic [1:0] flags, logic [7:0] nxt, logic last);
    res_t r;
    r            = '0;
    r.kind       = KIND_DESC;
    r.slot       = slot;
    r.address    = addr;
    r.length     = len;
    r.desc_flags = flags;
    r.next_slot  = nxt;
    r.status     = STS_OK;
    r.last       = last;
    return r;
  endfunction

  function automatic res_t index_res(kind_e kind, logic [7:0] slot, logic [15:0] idx,
                                     logic last);
    res_t r;
    r             = '0;
    r.kind        = kind;
    r.slot        = slot;
    r.index_value = idx;
    r.status      = STS_OK;
    r.last        = last;
    return r;
  endfunction

endpackage

[rtl/svq_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_front: command intake
// Takes input items, decodes the opcode and holds up to two commands for
// the engine.
// ----------------------------------------------------------------------------
module svq_front import svq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [8:0]  needed_count_i,
  input  logic [63:0] buffer_address_i,
  input  logic [31:0] buffer_length_i,
  input  logic        writable_i,
  input  logic [15:0] used_index_i,
  input  logic        suppress_notify_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_in;
  logic       push_ok, pop_ok;

  always_comb begin
    cmd_in.op       = op_e'(opcode_i);
    cmd_in.needed   = needed_count_i;
    cmd_in.addr     = buffer_address_i;
    cmd_in.len      = buffer_length_i;
    cmd_in.wr       = writable_i;
    cmd_in.used     = used_index_i;
    cmd_in.suppress = suppress_notify_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push_ok     = push && !full;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = push_ok ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_ok ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[rtl/svq_res_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_res_fifo: result queue
// Four-entry queue of result records between the engine and the consumer.
// ----------------------------------------------------------------------------
module svq_res_fifo import svq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  res_t data_i,
  output logic space_o,
  output logic empty,
  input  logic pop,
  output res_t data_o
);

  res_t       ent_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop_ok;

  assign empty   = (cnt_q == 3'd0);
  assign pop_ok  = pop && !empty;
  assign data_o  = ent_q[rd_ptr_q];
  // room for a whole burst of three results
  assign space_o = (cnt_q <= 3'd1);

  always_comb begin
    cnt_d = cnt_q + {2'b00, wr_i} - {2'b00, pop_ok};
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      cnt_q    <= 3'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/svq_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svq_engine: descriptor free list and chain builder
// Executes one command at a time against the link memory and the queue
// state, then hands its results to the result queue one per cycle.
// ----------------------------------------------------------------------------
module svq_engine import svq_pkg::*; #(
  parameter int MAX_QUEUE_DEPTH = 256
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_wr_t cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    space_i,
  output logic    res_we_o,
  output res_t    res_o
);

  localparam int Depth = (MAX_QUEUE_DEPTH < 256) ? MAX_QUEUE_DEPTH : 256;
  localparam int AW    = $clog2(Depth);
  localparam int QSW   = $clog2(Depth + 1);
  localparam logic [8:0] DepthV = 9'(Depth);

  eng_state_e state_q, state_d;

  logic [QSW-1:0] qs_q, qs_d;
  logic [15:0]    qnum_q, qnum_d;
  logic [AW-1:0]  free_head_q, free_head_d;
  logic [QSW-1:0] free_cnt_q, free_cnt_d;
  logic [15:0]    shadow_q, shadow_d;
  logic [AW-1:0]  ring_slot_q, ring_slot_d;
  logic [AW-1:0]  chain_head_q, chain_head_d;
  logic [AW-1:0]  chain_tail_q, chain_tail_d;
  logic [QSW-1:0] chain_cnt_q, chain_cnt_d;
  logic           waiting_q, waiting_d;
  logic [63:0]    tail_addr_q, tail_addr_d;
  logic [31:0]    tail_len_q, tail_len_d;
  logic [1:0]     tail_flags_q, tail_flags_d;

  cmd_t       cmd_q;
  res_t       res_q [3];
  res_t       res_d [3];
  logic [1:0] res_last_q, res_last_d;
  logic [1:0] emit_idx_q;

  // link memory with per-entry valid bits; an invalid entry reads as its
  // rebuilt link
  logic [AW-1:0]    link_mem [Depth];
  logic [Depth-1:0] link_vld_q;
  logic [AW-1:0]    rd_data_q;
  logic             rd_vld_q;
  logic             link_we;
  logic [AW-1:0]    link_wa, link_wd;
  logic             vld_clear;

  logic [QSW-1:0] fh_inc;
  logic [AW-1:0]  dflt_link, nxt;
  logic [QSW:0]   cnt_sum;
  logic [QSW-1:0] rs_inc;
  logic [15:0]    shadow_inc;
  logic [1:0]     fl;
  logic [8:0]     qs_new;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && space_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: state_d = S_EMIT;
      S_EMIT: begin
        if (emit_idx_q == res_last_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i && space_i;
    res_we_o  = (state_q == S_EMIT);
    res_o     = res_q[emit_idx_q];
  end

  always_comb begin
    fh_inc     = QSW'(free_head_q) + QSW'(1);
    dflt_link  = (fh_inc < qs_q) ? AW'(fh_inc) : '0;
    nxt        = rd_vld_q ? rd_data_q : dflt_link;
    cnt_sum    = {1'b0, free_cnt_q} + {1'b0, chain_cnt_q};
    rs_inc     = QSW'(ring_slot_q) + QSW'(1);
    shadow_inc = shadow_q + 16'd1;
    fl         = {cmd_q.wr, 1'b0};
    qs_new     = cfg_i.data[8:0];
    if (qs_new == 9'd0) begin
      qs_new = 9'd1;
    end
    if (qs_new > DepthV) begin
      qs_new = DepthV;
    end
  end

  // command execution and configuration
  always_comb begin
    qs_d         = qs_q;
    qnum_d       = qnum_q;
    free_head_d  = free_head_q;
    free_cnt_d   = free_cnt_q;
    shadow_d     = shadow_q;
    ring_slot_d  = ring_slot_q;
    chain_head_d = chain_head_q;
    chain_tail_d = chain_tail_q;
    chain_cnt_d  = chain_cnt_q;
    waiting_d    = waiting_q;
    tail_addr_d  = tail_addr_q;
    tail_len_d   = tail_len_q;
    tail_flags_d = tail_flags_q;
    res_d        = res_q;
    res_last_d   = res_last_q;
    link_we      = 1'b0;
    link_wa      = chain_tail_q;
    link_wd      = free_head_q;
    vld_clear    = 1'b0;

    if (state_q == S_EXEC) begin
      res_d[0]   = status_res(STS_OK);
      res_d[1]   = '0;
      res_d[2]   = '0;
      res_last_d = 2'd0;
      case (cmd_q.op)
        OP_USED: begin
          if (!waiting_q) begin
            res_d[0] = status_res(STS_OK);
          end else if (cmd_q.used != shadow_q) begin
            res_d[0] = status_res(STS_PENDING);
          end else begin
            // splice the chain in front of the free list
            link_we      = 1'b1;
            link_wa      = chain_tail_q;
            link_wd      = free_head_q;
            free_head_d  = chain_head_q;
            free_cnt_d   = (cnt_sum > {1'b0, qs_q}) ? qs_q : cnt_sum[QSW-1:0];
            chain_cnt_d  = '0;
            waiting_d    = 1'b0;
            res_d[0]     = desc_res(8'(chain_tail_q), tail_addr_q, tail_len_q,
                                    tail_flags_q, 8'(free_head_q), 1'b1);
          end
        end
        OP_RESERVE: begin
          if (waiting_q) begin
            res_d[0] = status_res(STS_BUSY);
          end else if (9'(free_cnt_q) < cmd_q.needed) begin
            res_d[0] = status_res(STS_TOO_FEW);
          end else begin
            chain_cnt_d = '0;
            res_d[0]    = status_res(STS_OK);
          end
        end
        OP_PUSH: begin
          if (waiting_q) begin
            res_d[0] = status_res(STS_BUSY);
          end else if (free_cnt_q == '0) begin
            res_d[0] = status_res(STS_TOO_FEW);
          end else begin
            res_d[0] = desc_res(8'(free_head_q), cmd_q.addr, cmd_q.len, fl, 8'(nxt),
                                chain_cnt_q == '0);
            if (chain_cnt_q != '0) begin
              // link the old tail to the new descriptor
              link_we    = 1'b1;
              link_wa    = chain_tail_q;
              link_wd    = free_head_q;
              res_d[1]   = desc_res(8'(chain_tail_q), tail_addr_q, tail_len_q,
                                    tail_flags_q | 2'b01, 8'(free_head_q), 1'b1);
              res_last_d = 2'd1;
            end else begin
              chain_head_d = free_head_q;
            end
            chain_tail_d = free_head_q;
            tail_addr_d  = cmd_q.addr;
            tail_len_d   = cmd_q.len;
            tail_flags_d = fl;
            free_head_d  = nxt;
            free_cnt_d   = free_cnt_q - QSW'(1);
            chain_cnt_d  = chain_cnt_q + QSW'(1);
          end
        end
        OP_SUBMIT: begin
          if (waiting_q) begin
            res_d[0] = status_res(STS_BUSY);
          end else if (chain_cnt_q == '0) begin
            res_d[0] = status_res(STS_EMPTY_CHAIN);
          end else begin
            res_d[0]   = index_res(KIND_RING, 8'(ring_slot_q), 16'(chain_head_q), 1'b0);
            res_d[1]   = index_res(KIND_PUBLISH, 8'd0, shadow_inc, cmd_q.suppress);
            res_d[2]   = index_res(KIND_NOTIFY, 8'd0, qnum_q, 1'b1);
            res_last_d = cmd_q.suppress ? 2'd1 : 2'd2;
            shadow_d   = shadow_inc;
            // ring slot tracks shadow modulo size; restart on index wrap
            if ((shadow_inc == 16'd0) || (rs_inc == qs_q)) begin
              ring_slot_d = '0;
            end else begin
              ring_slot_d = AW'(rs_inc);
            end
            waiting_d = 1'b1;
          end
        end
        default: res_d[0] = status_res(STS_OK);
      endcase
    end

    if (cfg_i.we) begin
      case (cfg_i.index)
        CFG_QUEUE_SIZE: begin
          qs_d         = QSW'(qs_new);
          free_head_d  = '0;
          free_cnt_d   = QSW'(qs_new);
          shadow_d     = '0;
          ring_slot_d  = '0;
          chain_head_d = '0;
          chain_tail_d = '0;
          chain_cnt_d  = '0;
          waiting_d    = 1'b0;
          tail_addr_d  = '0;
          tail_len_d   = '0;
          tail_flags_d = '0;
          vld_clear    = 1'b1;
        end
        CFG_QUEUE_NUMBER: qnum_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // link memory port: read at the free head on command pickup, write in exec
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd_pop_o) begin
      rd_data_q <= link_mem[free_head_q];
      rd_vld_q  <= link_vld_q[free_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      qs_q         <= QSW'(Depth);
      qnum_q       <= '0;
      free_head_q  <= '0;
      free_cnt_q   <= QSW'(Depth);
      shadow_q     <= '0;
      ring_slot_q  <= '0;
      chain_head_q <= '0;
      chain_tail_q <= '0;
      chain_cnt_q  <= '0;
      waiting_q    <= 1'b0;
      tail_addr_q  <= '0;
      tail_len_q   <= '0;
      tail_flags_q <= '0;
      res_last_q   <= '0;
      emit_idx_q   <= '0;
      link_vld_q   <= '0;
    end else begin
      state_q      <= state_d;
      qs_q         <= qs_d;
      qnum_q       <= qnum_d;
      free_head_q  <= free_head_d;
      free_cnt_q   <= free_cnt_d;
      shadow_q     <= shadow_d;
      ring_slot_q  <= ring_slot_d;
      chain_head_q <= chain_head_d;
      chain_tail_q <= chain_tail_d;
      chain_cnt_q  <= chain_cnt_d;
      waiting_q    <= waiting_d;
      tail_addr_q  <= tail_addr_d;
      tail_len_q   <= tail_len_d;
      tail_flags_q <= tail_flags_d;
      res_last_q   <= res_last_d;
      if (state_q == S_EXEC) begin
        emit_idx_q <= '0;
      end else if (state_q == S_EMIT) begin
        emit_idx_q <= emit_idx_q + 2'd1;
      end
      if (vld_clear) begin
        link_vld_q <= '0;
      end else if (link_we) begin
        link_vld_q[link_wa] <= 1'b1;
      end
    end
  end

endmodule

[rtl/split_virtqueue_descriptor_manager_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_virtqueue_descriptor_manager_core: driver side of a split virtqueue
// Keeps the descriptor free list, builds one chain at a time and emits the
// descriptor, ring, index and notify writes for it.
//
//   Channel   Handshake              Content
//   input     push / full            opcode and operands of one operation
//   result    empty / pop            kind, slot, descriptor fields, index,
//                                    status, last
//   config    cfg_valid / cfg_ready  register index and write data
//
// An operation yields n = 1..3 results: the link memory is read at pickup,
// ahead of execution, then the engine executes and hands its results to
// the result queue one per cycle; the engine starts only with room for three.
// Two commands queue in front of the engine, four results behind it.
// Reset and a queue size write rebuild the free list at once (all link valid
// bits are cleared together).
// ----------------------------------------------------------------------------
module split_virtqueue_descriptor_manager_core import svq_pkg::*; #(
  parameter int MAX_QUEUE_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          opcode_i,
  input  logic [8:0]          needed_count_i,
  input  logic [63:0]         buffer_address_i,
  input  logic [31:0]         buffer_length_i,
  input  logic                writable_i,
  input  logic [15:0]         used_index_i,
  input  logic                suppress_notify_i,
  output logic                empty,
  input  logic                pop,
  output logic [2:0]          kind_o,
  output logic [7:0]          slot_o,
  output logic [63:0]         address_o,
  output logic [31:0]         length_o,
  output logic [1:0]          desc_flags_o,
  output logic [7:0]          next_slot_o,
  output logic [15:0]         index_value_o,
  output logic [2:0]          status_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_wr_t cfg;
  logic    cmd_valid, cmd_pop;
  cmd_t    cmd;
  logic    space, res_we;
  res_t    res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign cfg.we      = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  svq_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .opcode_i          (opcode_i),
    .needed_count_i    (needed_count_i),
    .buffer_address_i  (buffer_address_i),
    .buffer_length_i   (buffer_length_i),
    .writable_i        (writable_i),
    .used_index_i      (used_index_i),
    .suppress_notify_i (suppress_notify_i),
    .cmd_valid_o       (cmd_valid),
    .cmd_o             (cmd),
    .cmd_pop_i         (cmd_pop)
  );

  svq_engine #(
    .MAX_QUEUE_DEPTH (MAX_QUEUE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .space_i     (space),
    .res_we_o    (res_we),
    .res_o       (res_in)
  );

  svq_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (res_we),
    .data_i  (res_in),
    .space_o (space),
    .empty   (empty),
    .pop     (pop),
    .data_o  (res_out)
  );

  assign kind_o        = res_out.kind;
  assign slot_o        = res_out.slot;
  assign address_o     = res_out.address;
  assign length_o      = res_out.length;
  assign desc_flags_o  = res_out.desc_flags;
  assign next_slot_o   = res_out.next_slot;
  assign index_value_o = res_out.index_value;
  assign status_o      = res_out.status;
  assign last_o        = res_out.last;

endmodule

[dv/split_virtqueue_descriptor_manager_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_virtqueue_descriptor_manager_checker: result predictor and scoreboard
// Watches the operation, result and register channels of the descriptor
// manager. It keeps its own free list, chain and ring index state and works
// out the writes each accepted operation must produce. Each popped result is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module split_virtqueue_descriptor_manager_checker import svq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  logic [1:0]          opcode_i,
  input  logic [8:0]          needed_count_i,
  input  logic [63:0]         buffer_address_i,
  input  logic [31:0]         buffer_length_i,
  input  logic                writable_i,
  input  logic [15:0]         used_index_i,
  input  logic                suppress_notify_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          slot_i,
  input  logic [63:0]         address_i,
  input  logic [31:0]         length_i,
  input  logic [1:0]          desc_flags_i,
  input  logic [7:0]          next_slot_i,
  input  logic [15:0]         index_value_i,
  input  logic [2:0]          status_i,
  input  logic                last_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  checked_o,
  output logic [15:0]         avail_index_o
);

  localparam int TableDepth = 256;

  logic [7:0]  link_mem [TableDepth];
  logic [1:0]  flag_mem [TableDepth];
  logic [7:0]  free_hd;
  logic [8:0]  free_cnt;
  logic [15:0] avail_idx;
  logic [7:0]  chain_hd;
  logic [7:0]  chain_tl;
  logic [8:0]  chain_len;
  logic        awaiting_used;
  logic [63:0] tail_addr;
  logic [31:0] tail_len;
  logic [8:0]  ring_size;
  logic [15:0] notify_value;

  res_t ring_writes_due [$];
  int   fails;
  int   checked;

  function automatic res_t make_write(kind_e kind, logic [7:0] slot, logic [63:0] addr,
                                      logic [31:0] len, logic [1:0] flags,
                                      logic [7:0] nxt, logic [15:0] idx,
                                      status_e st, logic last);
    res_t r;
    r.kind        = kind;
    r.slot        = slot;
    r.address     = addr;
    r.length      = len;
    r.desc_flags  = flags;
    r.next_slot   = nxt;
    r.index_value = idx;
    r.status      = st;
    r.last        = last;
    return r;
  endfunction

  task automatic expect_status(status_e st);
    ring_writes_due.push_back(make_write(KIND_STATUS, '0, '0, '0, '0, '0, '0, st, 1'b1));
  endtask

  task automatic rebuild_free_list();
    for (int i = 0; i < TableDepth; i++) begin
      link_mem[i] = (i + 1 < ring_size) ? 8'(i + 1) : 8'd0;
      flag_mem[i] = 2'b00;
    end
    free_hd       = '0;
    free_cnt      = ring_size;
    avail_idx     = '0;
    chain_hd      = '0;
    chain_tl      = '0;
    chain_len     = '0;
    awaiting_used = 1'b0;
    tail_addr     = '0;
    tail_len      = '0;
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic [8:0] sz;
    if (idx == CFG_QUEUE_SIZE) begin
      sz = data[8:0];
      if (sz == 9'd0) sz = 9'd1;
      if (sz > 9'(TableDepth)) sz = 9'(TableDepth);
      ring_size = sz;
      rebuild_free_list();
    end else if (idx == CFG_QUEUE_NUMBER) begin
      notify_value = data;
    end
  endtask

  // Predict the writes of one operation and advance the driver-side state.
  task automatic predict_ring_writes(op_e op, logic [8:0] need, logic [63:0] addr,
                                     logic [31:0] len, logic wr, logic [15:0] used,
                                     logic suppress);
    logic [7:0] h;
    logic [7:0] nxt;
    logic [7:0] t;
    logic [7:0] old;
    logic [1:0] fl;
    int         sum;
    int         ring_slot;
    if (op == OP_USED) begin
      if (!awaiting_used) begin
        expect_status(STS_OK);
      end else if (used != avail_idx) begin
        expect_status(STS_PENDING);
      end else begin
        // splice the finished chain back onto the free list
        t           = chain_tl;
        old         = free_hd;
        link_mem[t] = old;
        free_hd     = chain_hd;
        sum         = int'(free_cnt) + int'(chain_len);
        if (sum > int'(ring_size)) sum = int'(ring_size);
        free_cnt      = 9'(sum);
        chain_len     = '0;
        awaiting_used = 1'b0;
        ring_writes_due.push_back(make_write(KIND_DESC, t, tail_addr, tail_len,
                                             flag_mem[t], old, '0, STS_OK, 1'b1));
      end
    end else if (awaiting_used) begin
      expect_status(STS_BUSY);
    end else if (op == OP_RESERVE) begin
      if (free_cnt < need) begin
        expect_status(STS_TOO_FEW);
      end else begin
        chain_len = '0;
        expect_status(STS_OK);
      end
    end else if (op == OP_PUSH) begin
      if (free_cnt == 9'd0) begin
        expect_status(STS_TOO_FEW);
      end else begin
        h           = free_hd;
        nxt         = link_mem[h];
        fl          = wr ? 2'b10 : 2'b00;
        flag_mem[h] = fl;
        ring_writes_due.push_back(make_write(KIND_DESC, h, addr, len, fl, nxt, '0, STS_OK,
                                             chain_len == 9'd0));
        if (chain_len != 9'd0) begin
          t           = chain_tl;
          link_mem[t] = h;
          flag_mem[t] = flag_mem[t] | 2'b01;
          ring_writes_due.push_back(make_write(KIND_DESC, t, tail_addr, tail_len,
                                               flag_mem[t], h, '0, STS_OK, 1'b1));
        end else begin
          chain_hd = h;
        end
        chain_tl  = h;
        tail_addr = addr;
        tail_len  = len;
        free_hd   = nxt;
        free_cnt  = free_cnt - 9'd1;
        chain_len = chain_len + 9'd1;
      end
    end else begin
      if (chain_len == 9'd0) begin
        expect_status(STS_EMPTY_CHAIN);
      end else begin
        ring_slot = int'(avail_idx) % int'(ring_size);
        ring_writes_due.push_back(make_write(KIND_RING, 8'(ring_slot), '0, '0, '0, '0,
                                             16'(chain_hd), STS_OK, 1'b0));
        avail_idx = avail_idx + 16'd1;
        ring_writes_due.push_back(make_write(KIND_PUBLISH, '0, '0, '0, '0, '0, avail_idx,
                                             STS_OK, suppress));
        awaiting_used = 1'b1;
        if (!suppress) begin
          ring_writes_due.push_back(make_write(KIND_NOTIFY, '0, '0, '0, '0, '0,
                                               notify_value, STS_OK, 1'b1));
        end
      end
    end
  endtask

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fails++;
    end
  endtask

  task automatic check_popped_result();
    res_t want;
    if (ring_writes_due.size() == 0) begin
      $display("%0t ns: unexpected result, kind %0h slot %0h status %0h",
               $time, kind_i, slot_i, status_i);
      fails++;
      return;
    end
    want = ring_writes_due.pop_front();
    checked++;
    compare_field("kind", 64'(want.kind), 64'(kind_i));
    compare_field("slot", 64'(want.slot), 64'(slot_i));
    compare_field("address", want.address, address_i);
    compare_field("length", 64'(want.length), 64'(length_i));
    compare_field("desc_flags", 64'(want.desc_flags), 64'(desc_flags_i));
    compare_field("next_slot", 64'(want.next_slot), 64'(next_slot_i));
    compare_field("index_value", 64'(want.index_value), 64'(index_value_i));
    compare_field("status", 64'(want.status), 64'(status_i));
    compare_field("last", 64'(want.last), 64'(last_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size    = 9'(TableDepth);
      notify_value = '0;
      rebuild_free_list();
      ring_writes_due.delete();
      fails         = 0;
      checked       = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
      checked_o     <= 0;
      avail_index_o <= '0;
    end else begin
      // results come from earlier operations, so check before predicting
      if (pop_i && !empty_i) check_popped_result();
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (push_i && !full_i) begin
        predict_ring_writes(op_e'(opcode_i), needed_count_i, buffer_address_i,
                            buffer_length_i, writable_i, used_index_i, suppress_notify_i);
      end
      fail_count_o  <= fails;
      pending_o     <= ring_writes_due.size();
      checked_o     <= checked;
      avail_index_o <= avail_idx;
    end
  end

endmodule

[dv/tb_split_virtqueue_descriptor_manager_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_split_virtqueue_descriptor_manager_core: descriptor manager testbench
// Drives directed corner operations, then phases of random chains (reserve,
// pushes, submit, used index) mixed with stray operations, under several queue
// sizes and notify values. Sender bursts and receiver stalls are random; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_split_virtqueue_descriptor_manager_core;
  import svq_pkg::*;

  localparam int                 WatchdogLimit = 2000;
  localparam int                 RandomItems   = 400;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused  = 2'd3;

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                push              = 1'b0;
  logic                full;
  logic [1:0]          opcode            = '0;
  logic [8:0]          needed_count      = '0;
  logic [63:0]         buffer_address    = '0;
  logic [31:0]         buffer_length     = '0;
  logic                writable          = 1'b0;
  logic [15:0]         used_index        = '0;
  logic                suppress_notify   = 1'b0;
  logic                empty;
  logic                pop               = 1'b0;
  logic [2:0]          kind;
  logic [7:0]          slot;
  logic [63:0]         address;
  logic [31:0]         length;
  logic [1:0]          desc_flags;
  logic [7:0]          next_slot;
  logic [15:0]         index_value;
  logic [2:0]          status;
  logic                last;
  logic                cfg_valid         = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index         = '0;
  logic [CfgDataW-1:0] cfg_data          = '0;

  int          fail_count;
  int          pending_results;
  int          results_checked;
  logic [15:0] avail_index;

  logic rx_steady = 1'b0;
  int   rx_run    = 0;
  int   idle_cycles = 0;

  int items_sent   = 0;
  int burst_left   = 0;
  bit bursty       = 1'b1;
  int eff_size     = 256;
  int sizes_tried  = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  split_virtqueue_descriptor_manager_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .opcode_i          (opcode),
    .needed_count_i    (needed_count),
    .buffer_address_i  (buffer_address),
    .buffer_length_i   (buffer_length),
    .writable_i        (writable),
    .used_index_i      (used_index),
    .suppress_notify_i (suppress_notify),
    .empty             (empty),
    .pop               (pop),
    .kind_o            (kind),
    .slot_o            (slot),
    .address_o         (address),
    .length_o          (length),
    .desc_flags_o      (desc_flags),
    .next_slot_o       (next_slot),
    .index_value_o     (index_value),
    .status_o          (status),
    .last_o            (last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  split_virtqueue_descriptor_manager_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .full_i            (full),
    .opcode_i          (opcode),
    .needed_count_i    (needed_count),
    .buffer_address_i  (buffer_address),
    .buffer_length_i   (buffer_length),
    .writable_i        (writable),
    .used_index_i      (used_index),
    .suppress_notify_i (suppress_notify),
    .empty_i           (empty),
    .pop_i             (pop),
    .kind_i            (kind),
    .slot_i            (slot),
    .address_i         (address),
    .length_i          (length),
    .desc_flags_i      (desc_flags),
    .next_slot_i       (next_slot),
    .index_value_i     (index_value),
    .status_i          (status),
    .last_i            (last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending_results),
    .checked_o         (results_checked),
    .avail_index_o     (avail_index)
  );

  // Receiver: alternate runs of pops and stalls, or pop every cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop    <= 1'b0;
      rx_run <= 0;
    end else if (rx_steady) begin
      pop <= 1'b1;
    end else if (rx_run == 0) begin
      pop    <= ~pop;
      rx_run <= pop ? $urandom_range(0, 9) : $urandom_range(0, 5);
    end else begin
      rx_run <= rx_run - 1;
    end
  end

  // Watchdog: end the run when no channel has moved a transfer for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_results);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_address();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_length();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic pause(int cycles);
    push <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic send_op(op_e op, logic [8:0] need, logic [63:0] addr, logic [31:0] len,
                         logic wr, logic [15:0] used, logic suppress);
    push            <= 1'b1;
    opcode          <= op;
    needed_count    <= need;
    buffer_address  <= addr;
    buffer_length   <= len;
    writable        <= wr;
    used_index      <= used;
    suppress_notify <= suppress;
    do @(posedge clk_i); while (full);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (bursty) begin
      pause($urandom_range(1, 12));
      burst_left = $urandom_range(0, 7);
    end
  endtask

  task automatic send_random(op_e op, logic [8:0] need, logic [15:0] used);
    send_op(op, need, rand_address(), rand_length(), 1'($urandom), used, 1'($urandom));
  endtask

  task automatic wait_drained();
    pause(1);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    logic [8:0] sz;
    wait_drained();
    repeat (6) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_QUEUE_SIZE) begin
      sz = data[8:0];
      eff_size = (sz == 9'd0) ? 1 : ((sz > 9'd256) ? 256 : int'(sz));
      sizes_tried++;
    end
  endtask

  // One driver transaction: reserve, fill, submit, then the device's used index.
  task automatic run_chain();
    int n;
    n = $urandom_range(1, (eff_size < 6) ? eff_size : 6);
    if ($urandom_range(0, 6) == 0) begin
      send_random(OP_RESERVE, 9'($urandom_range(0, 511)), 16'($urandom));
    end else begin
      send_random(OP_RESERVE, 9'(n), 16'($urandom));
    end
    repeat (n) send_random(OP_PUSH, 9'($urandom), 16'($urandom));
    send_op(OP_SUBMIT, 9'($urandom), rand_address(), rand_length(), 1'($urandom),
            16'($urandom), $urandom_range(0, 3) == 0);
    // let the predicted index settle before sampling it
    pause($urandom_range(1, 4));
    if ($urandom_range(0, 4) == 0) begin
      send_random(OP_USED, 9'($urandom), avail_index ^ 16'($urandom_range(1, 65535)));
    end
    send_random(OP_USED, 9'($urandom), avail_index);
  endtask

  task automatic pick_size_setting();
    case ($urandom_range(0, 9))
      0:       write_reg(CFG_QUEUE_SIZE, 16'd0);
      1:       write_reg(CFG_QUEUE_SIZE, 16'd1);
      2:       write_reg(CFG_QUEUE_SIZE, 16'd2);
      3:       write_reg(CFG_QUEUE_SIZE, 16'd3);
      4:       write_reg(CFG_QUEUE_SIZE, 16'd5);
      5:       write_reg(CFG_QUEUE_SIZE, 16'd16);
      6:       write_reg(CFG_QUEUE_SIZE, 16'd255);
      7:       write_reg(CFG_QUEUE_SIZE, 16'd256);
      8:       write_reg(CFG_QUEUE_SIZE, 16'hFFFF);
      default: write_reg(CFG_QUEUE_SIZE, 16'($urandom_range(1, 300)));
    endcase
  endtask

  initial begin
    int target;
    int phase_end;
    int midpoint;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-size queue, extreme operands and every status.
    write_reg(CFG_QUEUE_NUMBER, 16'hFFFF);
    write_reg(CFG_QUEUE_SIZE, 16'h01FF);
    write_reg(CfgIdxUnused, 16'hA5A5);
    send_op(OP_RESERVE, 9'd256, '0, '0, 1'b0, 16'h0000, 1'b0);
    send_op(OP_PUSH, 9'd0, '1, '1, 1'b1, 16'hFFFF, 1'b1);
    send_op(OP_PUSH, 9'h1FF, '0, '0, 1'b0, 16'h0000, 1'b0);
    send_op(OP_SUBMIT, 9'd0, '1, '1, 1'b1, 16'hFFFF, 1'b0);
    send_random(OP_PUSH, 9'd0, 16'd0);                 // busy while waiting
    send_op(OP_USED, 9'd0, '0, '0, 1'b0, 16'hFFFE, 1'b0);  // index does not match yet
    send_op(OP_USED, 9'd0, '0, '0, 1'b0, 16'd1, 1'b0);     // splice back
    send_op(OP_USED, 9'd0, '0, '0, 1'b0, 16'd0, 1'b0);     // nothing waiting
    send_random(OP_SUBMIT, 9'd0, 16'd0);               // empty chain
    send_random(OP_RESERVE, 9'h1FF, 16'd0);            // too few free
    send_random(OP_PUSH, 9'd0, 16'd0);
    send_random(OP_RESERVE, 9'd0, 16'd0);              // drop the open chain
    send_random(OP_SUBMIT, 9'd0, 16'd0);
    send_random(OP_PUSH, 9'd0, 16'd0);
    send_op(OP_SUBMIT, 9'd0, '0, '0, 1'b0, 16'd0, 1'b1);   // notify suppressed
    send_random(OP_RESERVE, 9'd1, 16'd0);
    send_op(OP_USED, 9'd0, '0, '0, 1'b0, 16'd2, 1'b0);

    // Directed: zero size clamps to a single descriptor.
    write_reg(CFG_QUEUE_SIZE, 16'd0);
    write_reg(CFG_QUEUE_NUMBER, 16'd0);
    send_random(OP_RESERVE, 9'd2, 16'd0);
    send_random(OP_PUSH, 9'd0, 16'd0);
    send_random(OP_PUSH, 9'd0, 16'd0);                 // no free descriptor left
    send_op(OP_SUBMIT, 9'd0, '0, '0, 1'b0, 16'd0, 1'b0);
    send_op(OP_USED, 9'd0, '0, '0, 1'b0, 16'd1, 1'b0);

    // Random phases: mostly well-formed chains, some stray operations.
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      pick_size_setting();
      write_reg(CFG_QUEUE_NUMBER, 16'($urandom));
      bursty    = $urandom_range(0, 3) != 0;
      rx_steady <= $urandom_range(0, 3) == 0;
      phase_end = items_sent + $urandom_range(40, 80);
      midpoint  = (items_sent + phase_end) / 2;
      while (items_sent < phase_end && items_sent < target) begin
        if ($urandom_range(0, 3) != 0) begin
          run_chain();
        end else begin
          repeat ($urandom_range(1, 3)) begin
            send_random(op_e'($urandom_range(0, 3)), 9'($urandom), 16'($urandom));
          end
        end
        if (items_sent >= midpoint && midpoint != 0) begin
          // hold the sender until every outstanding result has been popped
          wait_drained();
          midpoint = 0;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d operations over %0d queue size settings, %0d results checked",
             items_sent, sizes_tried, results_checked);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/svq_pkg.sv
rtl/svq_front.sv
rtl/svq_res_fifo.sv
rtl/svq_engine.sv
rtl/split_virtqueue_descriptor_manager_core.sv
dv/split_virtqueue_descriptor_manager_checker.sv
dv/tb_split_virtqueue_descriptor_manager_core.sv
